// File: hw/rtl/averaged_range_to_pwm_duty_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the averaged range to PWM duty block
// Shared property forms, clocked on clk_i and disabled while rst_ni is low.
// ---------------------------------------------------------------------------
`ifndef AVERAGED_RANGE_TO_PWM_DUTY_DEFINES_SVH
`define AVERAGED_RANGE_TO_PWM_DUTY_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent
`define ARPD_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define ARPD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/arpd_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Averaged range to PWM duty package
// Widths, reset values, register indexes and shared types of the block.
// ---------------------------------------------------------------------------
package arpd_pkg;

  // Window size and field widths
  localparam int WINDOW_LOG2 = 4;
  localparam int RING_DEPTH  = 1 << WINDOW_LOG2;
  localparam int SAMPLE_W    = 12;
  localparam int SUM_W       = SAMPLE_W + WINDOW_LOG2;
  localparam int REG_W       = 16;
  localparam int DIST_W      = 20;
  localparam int DUTY_W      = 7;
  localparam int CMP_W       = 16;
  localparam int CM_W        = DIST_W - 8;

  // Shared multiplier widths
  localparam int MUL_W       = 24;
  localparam int PROD_W      = 2 * MUL_W;
  localparam int DIST_SHIFT  = WINDOW_LOG2 + 8;

  // Period times percent stays below 2^23; divide by 100 via reciprocal
  localparam int CMP_NUM_W   = 23;
  localparam int RECIP_SHIFT = 30;
  localparam logic [MUL_W-1:0] RECIP_MUL = 24'd10737419;

  localparam logic [DIST_W-1:0] DIST_MAX   = 20'hFFFFF;
  localparam logic [DUTY_W-1:0] DUTY_LIMIT = 7'd100;

  // Configuration registers
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_DISTANCE_SCALE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PWM_PERIOD     = 1'd1;
  localparam logic [REG_W-1:0] SCALE_RESET  = 16'd7012;
  localparam logic [REG_W-1:0] PERIOD_RESET = 16'd2499;

  // Request to the shared multiplier
  typedef struct packed {
    logic             en;
    logic [MUL_W-1:0] a;
    logic [MUL_W-1:0] b;
  } mul_req_t;

  // New sample pushed into the ring
  typedef struct packed {
    logic                push;
    logic [SAMPLE_W-1:0] sample;
  } ring_push_t;

endpackage

// File: hw/rtl/arpd_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Averaged range to PWM duty channels
// Valid/ready channels for the sample input and the result output.
// ---------------------------------------------------------------------------
interface arpd_in_if;
  logic                          valid;
  logic                          ready;
  logic [arpd_pkg::SAMPLE_W-1:0] adc_sample;

  modport source (output valid, output adc_sample, input ready);
  modport sink   (input valid, input adc_sample, output ready);
endinterface

interface arpd_out_if;
  logic                          valid;
  logic                          ready;
  logic [arpd_pkg::SAMPLE_W-1:0] average_sample;
  logic [arpd_pkg::DIST_W-1:0]   distance_q8;
  logic [arpd_pkg::DUTY_W-1:0]   duty_percent;
  logic [arpd_pkg::CMP_W-1:0]    compare_value;

  modport source (output valid, output average_sample, output distance_q8,
                  output duty_percent, output compare_value, input ready);
  modport sink   (input valid, input average_sample, input distance_q8,
                  input duty_percent, input compare_value, output ready);
endinterface

// File: hw/rtl/arpd_mul.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Shared multiplier
// One registered unsigned multiply, reused by the sequencer for all products.
// ---------------------------------------------------------------------------
module arpd_mul (
  input  logic                       clk_i,
  input  arpd_pkg::mul_req_t         req_i,
  output logic [arpd_pkg::PROD_W-1:0] prod_o
);
  import arpd_pkg::*;

  logic [PROD_W-1:0] prod_d;
  logic [PROD_W-1:0] prod_q;

  // Multiply the requested operands
  assign prod_d = req_i.a * req_i.b;

  // Capture the product when requested
  always_ff @(posedge clk_i) begin
    if (req_i.en) begin
      prod_q <= prod_d;
    end
  end

  assign prod_o = prod_q;

endmodule

// File: hw/rtl/arpd_ring.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Sample ring with running sum
// Replaces the oldest sample and keeps the window sum exact.
// ---------------------------------------------------------------------------
module arpd_ring (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  arpd_pkg::ring_push_t       push_i,
  output logic [arpd_pkg::SUM_W-1:0] sum_o
);
  import arpd_pkg::*;

  logic [SAMPLE_W-1:0]    ring_q [RING_DEPTH];
  logic [WINDOW_LOG2-1:0] slot_q;
  logic [WINDOW_LOG2-1:0] slot_d;
  logic [SUM_W-1:0]       sum_q;
  logic [SUM_W-1:0]       sum_d;

  // Drop the oldest sample from the sum and add the new one
  assign sum_d  = sum_q - SUM_W'(ring_q[slot_q]) + SUM_W'(push_i.sample);
  assign slot_d = slot_q + WINDOW_LOG2'(1);

  // Hold ring, slot pointer and sum; clear all at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < RING_DEPTH; i++) begin
        ring_q[i] <= '0;
      end
      slot_q <= '0;
      sum_q  <= '0;
    end else if (push_i.push) begin
      ring_q[slot_q] <= push_i.sample;
      slot_q         <= slot_d;
      sum_q          <= sum_d;
    end
  end

  assign sum_o = sum_q;

endmodule

// File: hw/rtl/averaged_range_to_pwm_duty.sv
`timescale 1ns / 1ps
// Sequence: after an input transfer the steps S_MUL_DIST, S_DUTY, S_MUL_CMP,
// S_MUL_RECIP and S_DONE run, and a new sample is taken only in S_IDLE; the sequencer runs
// three products through the single shared multiplier, then waits if the output is still full.
// Reset: the sample ring, pointer and sum clear to zero, distance_scale
// returns to 7012 and pwm_period to 2499; no clearing pass is needed.
// ---------------------------------------------------------------------------
// Averaged range to PWM duty
// Moving average of converter samples mapped to distance, duty and compare.
// ---------------------------------------------------------------------------
`include "averaged_range_to_pwm_duty_defines.svh"

module averaged_range_to_pwm_duty (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [arpd_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [arpd_pkg::REG_W-1:0]     cfg_wdata_i,
  arpd_in_if.sink                        in_if,
  arpd_out_if.source                     out_if
);
  import arpd_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL_DIST,
    S_DUTY,
    S_MUL_CMP,
    S_MUL_RECIP,
    S_DONE
  } state_e;

  state_e             state_q;
  logic [REG_W-1:0]   scale_q;
  logic [REG_W-1:0]   period_q;
  logic [DIST_W-1:0]  dist_q;
  logic [DUTY_W-1:0]  duty_q;
  logic               out_valid_q;
  logic [SAMPLE_W-1:0] avg_out_q;
  logic [DIST_W-1:0]  dist_out_q;
  logic [DUTY_W-1:0]  duty_out_q;
  logic [CMP_W-1:0]   cmp_out_q;

  ring_push_t         ring_push;
  logic [SUM_W-1:0]   sum;
  mul_req_t           mul_req;
  logic [PROD_W-1:0]  prod;
  logic [PROD_W-1:0]  dist_shift;
  logic [DIST_W-1:0]  dist_sat;
  logic [CM_W-1:0]    cm;
  logic [DUTY_W-1:0]  duty_d;
  logic               in_xfer;
  logic               out_xfer;

  assign in_xfer  = in_if.valid && in_if.ready;
  assign out_xfer = out_valid_q && out_if.ready;

  // Push each transferred sample into the ring
  assign ring_push.push   = in_xfer;
  assign ring_push.sample = in_if.adc_sample;

  arpd_ring u_ring (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (ring_push),
    .sum_o  (sum)
  );

  // Select the multiplier operands for the current step
  always_comb begin
    mul_req = '0;
    unique case (state_q)
      S_MUL_DIST: begin
        mul_req.en = 1'b1;
        mul_req.a  = MUL_W'(sum);
        mul_req.b  = MUL_W'(scale_q);
      end
      S_MUL_CMP: begin
        mul_req.en = 1'b1;
        mul_req.a  = MUL_W'(period_q);
        mul_req.b  = MUL_W'(duty_q);
      end
      S_MUL_RECIP: begin
        mul_req.en = 1'b1;
        mul_req.a  = MUL_W'(prod[CMP_NUM_W-1:0]);
        mul_req.b  = RECIP_MUL;
      end
      default: begin
        mul_req = '0;
      end
    endcase
  end

  arpd_mul u_mul (
    .clk_i  (clk_i),
    .req_i  (mul_req),
    .prod_o (prod)
  );

  // Scale the product to Q8 centimetres, saturate, clamp the percent
  assign dist_shift = prod >> DIST_SHIFT;
  assign dist_sat   = (dist_shift > PROD_W'(DIST_MAX)) ? DIST_MAX
                                                       : dist_shift[DIST_W-1:0];
  assign cm         = dist_sat[DIST_W-1:8];
  assign duty_d     = (cm > CM_W'(DUTY_LIMIT)) ? DUTY_LIMIT : cm[DUTY_W-1:0];

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q  <= SCALE_RESET;
      period_q <= PERIOD_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_DISTANCE_SCALE: scale_q  <= cfg_wdata_i;
        REG_PWM_PERIOD:     period_q <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  // Sequence the steps and hold the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      dist_q      <= '0;
      duty_q      <= '0;
      avg_out_q   <= '0;
      dist_out_q  <= '0;
      duty_out_q  <= '0;
      cmp_out_q   <= '0;
    end else begin
      // Drop valid after a transfer unless a new result loads this cycle
      if (out_xfer && (state_q != S_DONE)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_xfer) begin
            state_q <= S_MUL_DIST;
          end
        end
        S_MUL_DIST: begin
          state_q <= S_DUTY;
        end
        S_DUTY: begin
          dist_q  <= dist_sat;
          duty_q  <= duty_d;
          state_q <= S_MUL_CMP;
        end
        S_MUL_CMP: begin
          state_q <= S_MUL_RECIP;
        end
        S_MUL_RECIP: begin
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_q || out_if.ready) begin
            avg_out_q   <= sum[SUM_W-1:WINDOW_LOG2];
            dist_out_q  <= dist_q;
            duty_out_q  <= duty_q;
            cmp_out_q   <= prod[RECIP_SHIFT +: CMP_W];
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign in_if.ready           = (state_q == S_IDLE);
  assign out_if.valid          = out_valid_q;
  assign out_if.average_sample = avg_out_q;
  assign out_if.distance_q8    = dist_out_q;
  assign out_if.duty_percent   = duty_out_q;
  assign out_if.compare_value  = cmp_out_q;

  // Check sequencer and result consistency
  `ARPD_ASSERT_NEXT(a_busy_after_xfer, in_xfer, !in_if.ready, "ready after input transfer")
  `ARPD_ASSERT_SAME(a_duty_limit, out_valid_q, out_if.duty_percent <= DUTY_LIMIT, "duty above limit")
  `ARPD_ASSERT_SAME(a_duty_from_dist, out_valid_q && (out_if.distance_q8[DIST_W-1:8] <= CM_W'(DUTY_LIMIT)), CM_W'(out_if.duty_percent) == out_if.distance_q8[DIST_W-1:8], "duty not whole centimetres")
  `ARPD_ASSERT_SAME(a_mul_idle, state_q == S_IDLE || state_q == S_DONE, !mul_req.en, "multiplier used while idle")

endmodule
